### design/kmsd_pkg.sv
// kmsd_pkg: shared constants for the key to mux select decoder.
// Sizes of the board and top mux tree, field widths and register indexes.
// No dependencies.
`default_nettype none

package kmsd_pkg;

  // Tree shape
  localparam int MUXES_PER_BOARD = 4;
  localparam int TOP_MUXES       = 2;
  localparam int SELECT_LINES    = 4;
  localparam int KEY_BITS        = 12;

  // Register file layout: four child counts, then two top counts
  localparam int KPM_REGS = 4;
  localparam int MPT_REGS = 2;
  localparam int KPM_USED = (MUXES_PER_BOARD < KPM_REGS) ? MUXES_PER_BOARD : KPM_REGS;
  localparam int MPT_USED = (TOP_MUXES < MPT_REGS) ? TOP_MUXES : MPT_REGS;

  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_KPM_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MPT_BASE = 3'd4;

  // Internal widths
  localparam int SUM_W  = CNT_W + $clog2(MUXES_PER_BOARD);
  localparam int REM_W  = SUM_W;
  localparam int TCUM_W = CNT_W + $clog2(TOP_MUXES);
  localparam int CMUX_W = (MUXES_PER_BOARD > 1) ? $clog2(MUXES_PER_BOARD) : 1;
  localparam int TMUX_W = (TOP_MUXES > 1) ? $clog2(TOP_MUXES) : 1;
  localparam int G_W    = KEY_BITS + CMUX_W;

  // Result field widths
  localparam int IN_W  = 4;
  localparam int SEL_W = 4;

  localparam logic [SEL_W-1:0] SEL_MASK = SEL_W'((1 << SELECT_LINES) - 1);

endpackage : kmsd_pkg

`default_nettype wire

### design/key_to_mux_select_decode.sv
// key_to_mux_select_decode: pipelined key to board / child mux / top mux decoder.
// Depends on kmsd_pkg for tree sizes, widths and register indexes.
`default_nettype none

// Usage
// - Request channel: key_number is taken at a rising edge with start high and
//   busy low. busy is only high during reset, so a request may be issued on
//   every cycle.
// - Configuration: cfg_index / cfg_data written when cfg_valid and cfg_ready
//   are both high. Indexes 0..3 are keys per child mux, 4..5 child muxes per
//   top mux; other indexes are dropped. Write only while no request is in
//   flight.
// - Results: all result ports change together and done is high for exactly
//   one cycle; the receiver takes the result in that cycle and cannot stall.
// - Pipeline: the input register loads on the accepting edge, then one stage
//   per quotient bit of the restoring divider (12), the child mux search stage,
//   and the top mux search feeding the result register, which raises done.
//   Throughput is one request per cycle outside reset; the divider stages set
//   the depth.
// - Reset clears the count registers to zero and empties the pipeline;
//   requests in flight are dropped.
// - A negative key, an all-zero child count set or a failed child search give
//   key_found/top_found low and all-ones select lines; a failed top search does that for top only.

module key_to_mux_select_decode (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output      logic                            busy,
  input  wire logic signed [kmsd_pkg::KEY_BITS:0] key_number,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [kmsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kmsd_pkg::CNT_W-1:0]      cfg_data,
  output      logic                            done,
  output      logic                            key_found,
  output      logic [kmsd_pkg::KEY_BITS-1:0]   board_index,
  output      logic [kmsd_pkg::CMUX_W-1:0]     child_mux_index,
  output      logic [kmsd_pkg::IN_W-1:0]       child_input,
  output      logic                            top_found,
  output      logic [kmsd_pkg::TMUX_W-1:0]     top_mux_index,
  output      logic [kmsd_pkg::IN_W-1:0]       top_input,
  output      logic [kmsd_pkg::SEL_W-1:0]      child_select_lines,
  output      logic [kmsd_pkg::SEL_W-1:0]      top_select_lines
);
  import kmsd_pkg::*;

  // Count registers
  logic [CNT_W-1:0] kpm [MUXES_PER_BOARD];
  logic [CNT_W-1:0] mpt [TOP_MUXES];

  // Keys per board; the user must change counts only while the pipe is empty, the block does not enforce it
  logic [SUM_W-1:0] sum;

  // Divider pipe: stage 0 is the input register, stage k has k quotient bits
  logic                dvld [0:KEY_BITS];
  logic                dok  [0:KEY_BITS];
  logic [REM_W-1:0]    drem [0:KEY_BITS];
  logic [KEY_BITS-1:0] dkey [0:KEY_BITS];
  logic [KEY_BITS-1:0] dquo [0:KEY_BITS];

  logic [REM_W-1:0]    drem_next [1:KEY_BITS];
  logic [KEY_BITS-1:0] dkey_next [1:KEY_BITS];
  logic [KEY_BITS-1:0] dquo_next [1:KEY_BITS];

  // Child search stage
  logic                c_vld;
  logic                c_kf;
  logic [KEY_BITS-1:0] c_board;
  logic [CMUX_W-1:0]   c_cmux;
  logic [IN_W-1:0]     c_cin;

  logic                c_kf_next;
  logic [CMUX_W-1:0]   c_cmux_next;
  logic [IN_W-1:0]     c_cin_next;

  // Top search
  logic                tf_next;
  logic [TMUX_W-1:0]   tmux_next;
  logic [IN_W-1:0]     tin_next;

  assign busy      = rst;
  assign cfg_ready = ~rst;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MUXES_PER_BOARD; i++) kpm[i] <= '0;
      for (int i = 0; i < TOP_MUXES; i++) mpt[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      for (int i = 0; i < KPM_USED; i++) begin
        if (cfg_index == CFG_KPM_BASE + CFG_IDX_W'(i)) kpm[i] <= cfg_data;
      end
      for (int i = 0; i < MPT_USED; i++) begin
        if (cfg_index == CFG_MPT_BASE + CFG_IDX_W'(i)) mpt[i] <= cfg_data;
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < MUXES_PER_BOARD; i++) sum = sum + SUM_W'(kpm[i]);
  end

  // ---------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage (MSB first)
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [REM_W:0] t;
    logic           ge;
    for (int k = 0; k < KEY_BITS; k++) begin
      t  = {drem[k], dkey[k][KEY_BITS-1]};
      ge = (t >= (REM_W+1)'(sum));
      drem_next[k+1] = ge ? REM_W'(t - (REM_W+1)'(sum)) : REM_W'(t);
      dkey_next[k+1] = {dkey[k][KEY_BITS-2:0], 1'b0};
      dquo_next[k+1] = {dquo[k][KEY_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= KEY_BITS; k++) dvld[k] <= 1'b0;
    end else begin
      dvld[0] <= start && !busy;
      for (int k = 1; k <= KEY_BITS; k++) dvld[k] <= dvld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    dok[0]  <= ~key_number[KEY_BITS];
    dkey[0] <= key_number[KEY_BITS-1:0];
    drem[0] <= '0;
    dquo[0] <= '0;
    for (int k = 1; k <= KEY_BITS; k++) begin
      dok[k]  <= dok[k-1];
      drem[k] <= drem_next[k];
      dkey[k] <= dkey_next[k];
      dquo[k] <= dquo_next[k];
    end
  end

  // ---------------------------------------------------------------------------
  // Child mux search: first mux whose cumulative count passes the remainder
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [SUM_W-1:0] cum;
    logic [SUM_W-1:0] nxt;
    logic             hit;
    cum         = '0;
    hit         = 1'b0;
    c_cmux_next = '0;
    c_cin_next  = '0;
    for (int i = 0; i < MUXES_PER_BOARD; i++) begin
      nxt = cum + SUM_W'(kpm[i]);
      if (!hit && (drem[KEY_BITS] < nxt)) begin
        hit         = 1'b1;
        c_cmux_next = CMUX_W'(i);
        c_cin_next  = IN_W'(drem[KEY_BITS] - cum);
      end
      cum = nxt;
    end
    c_kf_next = dok[KEY_BITS] && (sum != '0) && hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= dvld[KEY_BITS];
    end
  end

  always_ff @(posedge clk) begin
    c_kf    <= c_kf_next;
    c_board <= c_kf_next ? dquo[KEY_BITS] : '0;
    c_cmux  <= c_kf_next ? c_cmux_next : '0;
    c_cin   <= c_kf_next ? c_cin_next : '0;
  end

  // ---------------------------------------------------------------------------
  // Top mux search on the global mux index
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [G_W-1:0]    g;
    logic [TCUM_W-1:0] cum;
    logic [TCUM_W-1:0] nxt;
    logic              hit;
    g         = G_W'(c_board) * G_W'(MUXES_PER_BOARD) + G_W'(c_cmux);
    cum       = '0;
    hit       = 1'b0;
    tmux_next = '0;
    tin_next  = '0;
    for (int i = 0; i < TOP_MUXES; i++) begin
      nxt = cum + TCUM_W'(mpt[i]);
      if (!hit && (g < G_W'(nxt))) begin
        hit       = 1'b1;
        tmux_next = TMUX_W'(i);
        tin_next  = IN_W'(g - G_W'(cum));
      end
      cum = nxt;
    end
    tf_next = c_kf && hit;
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    key_found          <= c_kf;
    board_index        <= c_board;
    child_mux_index    <= c_cmux;
    child_input        <= c_cin;
    top_found          <= tf_next;
    top_mux_index      <= tf_next ? tmux_next : '0;
    top_input          <= tf_next ? tin_next : '0;
    child_select_lines <= c_kf ? (SEL_W'(c_cin) & SEL_MASK) : SEL_MASK;
    top_select_lines   <= tf_next ? (SEL_W'(tin_next) & SEL_MASK) : SEL_MASK;
  end

endmodule : key_to_mux_select_decode

`default_nettype wire
